FILE: src/msp_rx_pkg.sv
// Shared types and constants for the MSP frame receiver.
package msp_rx_pkg;

	localparam logic [7:0] SYM_DOLLAR = 8'h24;
	localparam logic [7:0] SYM_M      = 8'h4D;
	localparam logic [7:0] SYM_LT     = 8'h3C;

	localparam logic [7:0] MAX_LENGTH_RESET = 8'd29;
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		ST_PAYLOAD  = 2'd0,
		ST_CSUM_OK  = 2'd1,
		ST_CSUM_BAD = 2'd2,
		ST_LEN_REJ  = 2'd3
	} status_t;

	typedef enum logic [5:0] {
		PH_HUNT    = 6'b000001,
		PH_WANT_M  = 6'b000010,
		PH_WANT_LT = 6'b000100,
		PH_COUNT   = 6'b001000,
		PH_DATA    = 6'b010000,
		PH_CHECK   = 6'b100000
	} phase_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic       last;
	} res_word_t;

endpackage

FILE: src/msp_rx_front.sv
// Header hunt, length check and checksum tracking; emits result words.
module msp_rx_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  max_length_we,
	input  logic [7:0]            max_length_wdata,
	input  logic                  rx_valid,
	input  logic                  rx_stall,
	input  logic [7:0]            rx_byte,
	output logic                  push,
	output msp_rx_pkg::res_word_t push_word
);
	import msp_rx_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] max_length_q;
	logic [7:0] bytes_left_q, bytes_left_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] next_index_q, next_index_d;
	logic       accept;
	phase_t     restart;

	assign accept  = rx_valid && !rx_stall;
	assign restart = (rx_byte == SYM_DOLLAR) ? PH_WANT_M : PH_HUNT;

	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		xor_d        = xor_q;
		next_index_d = next_index_q;
		push         = 1'b0;
		push_word    = '{status: ST_PAYLOAD, payload_byte: rx_byte,
			byte_index: 8'd0, last: 1'b0};
		if (accept) begin
			unique case (phase_q)
				PH_WANT_M: begin
					phase_d = (rx_byte == SYM_M) ? PH_WANT_LT : restart;
				end
				PH_WANT_LT: begin
					phase_d = (rx_byte == SYM_LT) ? PH_COUNT : restart;
				end
				PH_COUNT: begin
					if (rx_byte > max_length_q) begin
						push             = 1'b1;
						push_word.status = ST_LEN_REJ;
						push_word.last   = 1'b1;
						phase_d          = PH_HUNT;
					end else begin
						bytes_left_d = rx_byte;
						xor_d        = 8'd0;
						next_index_d = 8'd0;
						phase_d      = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
					end
				end
				PH_DATA: begin
					push                 = 1'b1;
					push_word.byte_index = next_index_q;
					xor_d                = xor_q ^ rx_byte;
					next_index_d         = next_index_q + 8'd1;
					bytes_left_d         = bytes_left_q - 8'd1;
					if (bytes_left_q == 8'd1) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					push             = 1'b1;
					push_word.status = (rx_byte == xor_q) ? ST_CSUM_OK : ST_CSUM_BAD;
					push_word.last   = 1'b1;
					phase_d          = PH_HUNT;
				end
				default: begin
					phase_d = restart;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			max_length_q <= MAX_LENGTH_RESET;
			bytes_left_q <= 8'd0;
			xor_q        <= 8'd0;
			next_index_q <= 8'd0;
		end else begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			xor_q        <= xor_d;
			next_index_q <= next_index_d;
			if (max_length_we) begin
				max_length_q <= max_length_wdata;
			end
		end
	end

`ifndef SYNTHESIS
	a_data_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> bytes_left_q != 8'd0)
		else $error("payload phase with no bytes left");
	a_end_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_word.last |-> push_word.byte_index == 8'd0 &&
			push_word.status != ST_PAYLOAD)
		else $error("frame end word malformed");
`endif

endmodule

FILE: src/msp_rx_queue.sv
// Short word queue between parser and output stage.
module msp_rx_queue #(
	parameter int unsigned Depth = msp_rx_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  msp_rx_pkg::res_word_t push_word,
	input  logic                  pop,
	output msp_rx_pkg::res_word_t head_word,
	output logic                  empty,
	output logic                  full
);
	import msp_rx_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

	res_word_t       mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign empty     = (count_q == '0);
	assign full      = (count_q == DepthCnt);
	assign head_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
`endif

endmodule

FILE: src/msp_rx_back.sv
// Output register stage draining the queue onto the result channel.
module msp_rx_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  msp_rx_pkg::res_word_t head_word,
	input  logic                  empty,
	output logic                  pop,
	output logic                  res_valid,
	input  logic                  res_stall,
	output msp_rx_pkg::res_word_t res_word
);
	import msp_rx_pkg::*;

	logic      valid_q;
	res_word_t word_q;
	logic      take;

	assign take      = !valid_q || !res_stall;
	assign pop       = take && !empty;
	assign res_valid = valid_q;
	assign res_word  = word_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= head_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= !empty;
		end
	end

endmodule

FILE: src/msp_frame_receiver_xor_check_top.sv
// A result word passes through the queue, then the output register that drives res_valid.
// One byte per cycle unless rx_stall; header and in-range count bytes give no result.
// rx_stall rises only when the result queue (Depth words) is full.
// Reset (async, arst_n low): parser hunts for '$', queue empties, res_valid low.
// Reset sets max_length to 29.
// Top level of the MSP frame receiver with XOR checksum check.
module msp_frame_receiver_xor_check_top #(
	parameter int unsigned Depth = msp_rx_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       max_length_we,
	input  logic [7:0] max_length_wdata,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] status,
	output logic [7:0] payload_byte,
	output logic [7:0] byte_index,
	output logic       last
);
	import msp_rx_pkg::*;

	logic      push, pop, empty, full;
	res_word_t push_word, head_word, res_word;

	assign rx_stall = full;

	msp_rx_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.max_length_we    (max_length_we),
		.max_length_wdata (max_length_wdata),
		.rx_valid         (rx_valid),
		.rx_stall         (rx_stall),
		.rx_byte          (rx_byte),
		.push             (push),
		.push_word        (push_word)
	);

	msp_rx_queue #(
		.Depth (Depth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head_word (head_word),
		.empty     (empty),
		.full      (full)
	);

	msp_rx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_word (head_word),
		.empty     (empty),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	assign status       = res_word.status;
	assign payload_byte = res_word.payload_byte;
	assign byte_index   = res_word.byte_index;
	assign last         = res_word.last;

endmodule
